FILE: design/grid_steepest_ascent_walk_assert.svh
// ----------------------------------------------------------------------------
// grid_steepest_ascent_walk assertion macros
// concurrent checks that vanish when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GRID_STEEPEST_ASCENT_WALK_ASSERT_SVH
`define GRID_STEEPEST_ASCENT_WALK_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define GSAW_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gsaw assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GSAW_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gsaw assertion failed");

`else

`define GSAW_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define GSAW_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: design/gsaw_pkg.sv
// ----------------------------------------------------------------------------
// gsaw_pkg
// shared types and constants of the grid steepest ascent walk
// ----------------------------------------------------------------------------
package gsaw_pkg;

    localparam int DATA_W       = 32;
    localparam int DIM_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_FETCH,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > max_dim)
            r = DIM_W'(max_dim);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: design/grid_steepest_ascent_walk.sv
// ----------------------------------------------------------------------------
// grid_steepest_ascent_walk
// loads a signed matrix row by row, then climbs from cell (0,0) to a peak
// ----------------------------------------------------------------------------
// usage
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets num_rows and
//   num_cols; cfg_ready is always high, write only while the block is idle
//   a cell word is taken at each clock edge with start high and busy low,
//   one word per cycle while loading, row-major order
//   the word that completes the grid raises busy and starts the climb
//   steps from the last cell taken to the first path value, in order:
//   start and fetch of cell (0,0), a scan of the nine positions around it through
//   the single read port of the cell store, one compare drain, one decide
//   each further path value follows another scan, drain and decide
//   results: result_valid marks path_value/path_last for one cycle only;
//   path_last flags the peak, and busy drops in that same cycle
//   the receiver cannot stall, results must be taken as they appear
//   reset: grid size goes to 8 by 8, load count and position clear,
//   the cell store keeps whatever it holds until loaded
// ----------------------------------------------------------------------------
`include "grid_steepest_ascent_walk_assert.svh"

module grid_steepest_ascent_walk #(
    parameter int MAX_ROWS = gsaw_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gsaw_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // cell word channel
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gsaw_pkg::DATA_W-1:0]  cell_value,
    // result channel
    output logic                                result_valid,
    output logic signed [gsaw_pkg::DATA_W-1:0]  path_value,
    output logic                                path_last,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gsaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsaw_pkg::DIM_W-1:0]          cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PROD_W = ADDR_W + gsaw_pkg::DIM_W;
    localparam int DIM_W  = gsaw_pkg::DIM_W;
    localparam int NB_W   = 8;  // neighbor coordinate math, covers any grid size

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= gsaw_pkg::DIM_RESET;
            num_cols_reg <= gsaw_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gsaw_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                gsaw_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid size
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;

    assign rows  = gsaw_pkg::clamp_dim(num_rows_reg, MAX_ROWS);
    assign cols  = gsaw_pkg::clamp_dim(num_cols_reg, MAX_COLS);
    assign total = CNT_W'({{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols});

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    gsaw_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [1:0]       dr_reg, dr_next;      // scan offset, row
    logic [1:0]       dc_reg, dc_next;      // scan offset, column
    logic             moved_reg, moved_next;
    logic             p1_valid_reg, p1_valid_next;
    logic             result_valid_reg, result_valid_next;

    // payload, no reset
    logic signed [gsaw_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic signed [gsaw_pkg::DATA_W-1:0] best_reg, best_next;
    logic [ROW_W-1:0]                   best_row_reg, best_row_next;
    logic [COL_W-1:0]                   best_col_reg, best_col_next;
    logic [ROW_W-1:0]                   p1_row_reg, p1_row_next;
    logic [COL_W-1:0]                   p1_col_reg, p1_col_next;
    logic signed [gsaw_pkg::DATA_W-1:0] path_value_reg, path_value_next;
    logic                               path_last_reg, path_last_next;

    // cell store ports
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [gsaw_pkg::DATA_W-1:0] ram_rdata;

    gsaw_cell_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cell_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // load slot: a count left over from a larger grid lands on the last cell
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] load_slot;
    logic             load_done;
    logic             accept;

    assign busy      = (state_reg != gsaw_pkg::ST_LOAD);
    assign accept    = start && !busy;
    assign load_slot = (load_count_reg >= total) ? (total - CNT_W'(1)) : load_count_reg;
    assign load_done = (load_slot == (total - CNT_W'(1)));

    // ------------------------------------------------------------------
    // neighbor under scan: validity and store address
    // ------------------------------------------------------------------
    logic [NB_W-1:0]   nb_row;
    logic [NB_W-1:0]   nb_col;
    logic              nb_valid;
    logic [PROD_W-1:0] nb_addr;

    assign nb_row   = NB_W'(cur_row_reg) + NB_W'(dr_reg) - NB_W'(1);
    assign nb_col   = NB_W'(cur_col_reg) + NB_W'(dc_reg) - NB_W'(1);
    assign nb_valid = !(cur_row_reg == '0 && dr_reg == 2'd0)
                   && !(cur_col_reg == '0 && dc_reg == 2'd0)
                   && (nb_row < NB_W'(rows))
                   && (nb_col < NB_W'(cols));
    assign nb_addr  = PROD_W'(nb_row[ROW_W-1:0]) * PROD_W'(cols)
                    + PROD_W'(nb_col[COL_W-1:0]);

    // read data from the previous scan cycle beats the best so far
    logic rd_wins;
    assign rd_wins = p1_valid_reg && ($signed(ram_rdata) > best_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        load_count_next   = load_count_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        dr_next           = dr_reg;
        dc_next           = dc_reg;
        moved_next        = moved_reg;
        p1_valid_next     = 1'b0;
        result_valid_next = 1'b0;
        cur_next          = cur_reg;
        best_next         = best_reg;
        best_row_next     = best_row_reg;
        best_col_next     = best_col_reg;
        p1_row_next       = nb_row[ROW_W-1:0];
        p1_col_next       = nb_col[COL_W-1:0];
        path_value_next   = path_value_reg;
        path_last_next    = path_last_reg;
        ram_we            = 1'b0;
        ram_waddr         = load_slot[ADDR_W-1:0];
        ram_re            = 1'b0;
        ram_raddr         = nb_addr[ADDR_W-1:0];

        // compare stage runs behind the scan reads
        if (rd_wins)
        begin
            best_next     = ram_rdata;
            best_row_next = p1_row_reg;
            best_col_next = p1_col_reg;
            moved_next    = 1'b1;
        end

        unique case (state_reg)
            gsaw_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    ram_we = 1'b1;
                    if (load_done)
                    begin
                        load_count_next = '0;
                        state_next      = gsaw_pkg::ST_START;
                    end
                    else
                    begin
                        load_count_next = load_slot + CNT_W'(1);
                    end
                end
            end

            gsaw_pkg::ST_START:
            begin
                // cell (0,0), already in the store
                ram_re       = 1'b1;
                ram_raddr    = '0;
                cur_row_next = '0;
                cur_col_next = '0;
                state_next   = gsaw_pkg::ST_FETCH;
            end

            gsaw_pkg::ST_FETCH:
            begin
                cur_next   = ram_rdata;
                best_next  = ram_rdata;
                moved_next = 1'b0;
                dr_next    = 2'd0;
                dc_next    = 2'd0;
                state_next = gsaw_pkg::ST_SCAN;
            end

            gsaw_pkg::ST_SCAN:
            begin
                ram_re        = nb_valid;
                p1_valid_next = nb_valid;
                if (dc_reg == 2'd2)
                begin
                    dc_next = 2'd0;
                    if (dr_reg == 2'd2)
                        state_next = gsaw_pkg::ST_DRAIN;
                    else
                        dr_next = dr_reg + 2'd1;
                end
                else
                begin
                    dc_next = dc_reg + 2'd1;
                end
            end

            gsaw_pkg::ST_DRAIN:
            begin
                state_next = gsaw_pkg::ST_DECIDE;
            end

            gsaw_pkg::ST_DECIDE:
            begin
                result_valid_next = 1'b1;
                path_value_next   = cur_reg;
                path_last_next    = !moved_reg;
                if (moved_reg)
                begin
                    cur_next     = best_reg;
                    cur_row_next = best_row_reg;
                    cur_col_next = best_col_reg;
                    moved_next   = 1'b0;
                    dr_next      = 2'd0;
                    dc_next      = 2'd0;
                    state_next   = gsaw_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = gsaw_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = gsaw_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gsaw_pkg::ST_LOAD;
            load_count_reg   <= '0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            dr_reg           <= 2'd0;
            dc_reg           <= 2'd0;
            moved_reg        <= 1'b0;
            p1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            dr_reg           <= dr_next;
            dc_reg           <= dc_next;
            moved_reg        <= moved_next;
            p1_valid_reg     <= p1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_row_reg   <= best_row_next;
        best_col_reg   <= best_col_next;
        p1_row_reg     <= p1_row_next;
        p1_col_reg     <= p1_col_next;
        path_value_reg <= path_value_next;
        path_last_reg  <= path_last_next;
    end

    assign result_valid = result_valid_reg;
    assign path_value   = path_value_reg;
    assign path_last    = path_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a peak decision shows up as the last word with the block idle again
    `GSAW_ASSERT_NEXT(a_peak_ends_walk, clk, rst_n,
        (state_reg == gsaw_pkg::ST_DECIDE && !moved_reg),
        (result_valid && path_last && !busy))

    // more path values pending keeps the block busy
    `GSAW_ASSERT_IMPLIES(a_mid_path_busy, clk, rst_n,
        (result_valid && !path_last), busy)

    // neighbor compares only trail scan reads
    `GSAW_ASSERT_IMPLIES(a_compare_in_scan, clk, rst_n, p1_valid_reg,
        (state_reg == gsaw_pkg::ST_SCAN || state_reg == gsaw_pkg::ST_DRAIN))

endmodule

FILE: design/gsaw_cell_ram.sv
// ----------------------------------------------------------------------------
// gsaw_cell_ram
// cell store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gsaw_cell_ram #(
    parameter int DEPTH  = gsaw_pkg::DEF_MAX_ROWS * gsaw_pkg::DEF_MAX_COLS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [gsaw_pkg::DATA_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [gsaw_pkg::DATA_W-1:0] rdata
);

    logic [gsaw_pkg::DATA_W-1:0] mem [DEPTH];
    logic [gsaw_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/grid_steepest_ascent_walk_test.sv
// ----------------------------------------------------------------------------
// grid_steepest_ascent_walk_test
// loads signed grids of many shapes and checks every climb path word
// against a predictor that mirrors the load counter, cell store and climb
// ----------------------------------------------------------------------------
module grid_steepest_ascent_walk_test;

    localparam int DATA_W    = gsaw_pkg::DATA_W;
    localparam int DIM_W     = gsaw_pkg::DIM_W;
    localparam int CFG_IDX_W = gsaw_pkg::CFG_IDX_W;
    localparam int ROWS_MAX  = gsaw_pkg::DEF_MAX_ROWS;
    localparam int COLS_MAX  = gsaw_pkg::DEF_MAX_COLS;
    localparam int CELLS_MAX = ROWS_MAX * COLS_MAX;
    // cycles to let pass before touching the registers
    localparam int SETTLE_CYCLES = 16;

    // pattern families for cell contents
    typedef enum int {
        FILL_RANDOM,
        FILL_TIES,
        FILL_RAMP,
        FILL_EXTREME
    } fill_t;

    // one expected path word
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } path_word_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block inputs, all known from time zero
    logic                       start = 1'b0;
    logic signed [DATA_W-1:0]   cell_value = '0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [DIM_W-1:0]           cfg_data = '0;

    // block outputs
    logic                       busy;
    logic                       result_valid;
    logic signed [DATA_W-1:0]   path_value;
    logic                       path_last;
    logic                       cfg_ready;

    grid_steepest_ascent_walk uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cell_value   (cell_value),
        .result_valid (result_valid),
        .path_value   (path_value),
        .path_last    (path_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // cell words waiting to be driven, path words waiting to come out
    logic signed [DATA_W-1:0] cell_q[$];
    path_word_t               path_expect_q[$];

    // predictor state: register copies, load counter, cell store
    logic [DIM_W-1:0]         rows_reg = gsaw_pkg::DIM_RESET;
    logic [DIM_W-1:0]         cols_reg = gsaw_pkg::DIM_RESET;
    int                       cells_loaded = 0;
    logic signed [DATA_W-1:0] grid_mem [CELLS_MAX];

    // sender idle chance in percent
    int idle_pct = 37;

    // bookkeeping
    int cells_pushed = 0;
    int cells_taken  = 0;
    int climbs_seen  = 0;
    int words_seen   = 0;
    int reg_writes   = 0;
    int err_count    = 0;

    // zero counts as one, oversize counts as the maximum
    function automatic int fit_dim(input logic [DIM_W-1:0] raw, input int limit);
        int d;
        d = int'(raw);
        if (d < 1)
            d = 1;
        if (d > limit)
            d = limit;
        return d;
    endfunction

    // take one cell word; the word that completes the grid runs the climb
    function automatic void absorb_cell(input logic signed [DATA_W-1:0] v);
        int rows, cols, total, steps;
        int cur_r, cur_c, best_r, best_c, r, c;
        logic signed [DATA_W-1:0] cur_v, best_v;
        bit moved;
        rows  = fit_dim(rows_reg, ROWS_MAX);
        cols  = fit_dim(cols_reg, COLS_MAX);
        total = rows * cols;
        // a shrunk grid turns an overrun load into its last cell
        if (cells_loaded >= total)
            cells_loaded = total - 1;
        grid_mem[cells_loaded] = v;
        if (cells_loaded + 1 < total)
        begin
            cells_loaded++;
            return;
        end
        cells_loaded = 0;
        climbs_seen++;
        cur_r = 0;
        cur_c = 0;
        cur_v = grid_mem[0];
        steps = 1;
        moved = 1'b1;
        while (moved && steps < total)
        begin
            moved  = 1'b0;
            best_v = cur_v;
            best_r = cur_r;
            best_c = cur_c;
            // row-major neighborhood scan, strict compare keeps the first tie
            for (r = cur_r - 1; r <= cur_r + 1; r++)
                for (c = cur_c - 1; c <= cur_c + 1; c++)
                    if (r >= 0 && c >= 0 && r < rows && c < cols &&
                        grid_mem[r * cols + c] > best_v)
                    begin
                        best_v = grid_mem[r * cols + c];
                        best_r = r;
                        best_c = c;
                        moved  = 1'b1;
                    end
            if (moved)
            begin
                path_expect_q.push_back('{value: cur_v, last: 1'b0});
                cur_r = best_r;
                cur_c = best_c;
                cur_v = best_v;
                steps++;
            end
        end
        // the peak closes the path
        path_expect_q.push_back('{value: cur_v, last: 1'b1});
    endfunction

    // driver: one cell word per handshake, random sender gaps
    always @(posedge clk)
    begin : feed
        logic                     go;
        logic signed [DATA_W-1:0] word;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cell_value <= '0;
        end
        else
        begin
            go   = start;
            word = cell_value;
            // word taken at this edge
            if (start && !busy)
            begin
                absorb_cell(cell_value);
                cells_taken++;
                go = 1'b0;
            end
            if (!go)
            begin
                // junk on the data lines while start is low
                word = $urandom;
                if (cell_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    word = cell_q.pop_front();
                    go   = 1'b1;
                end
            end
            start      <= go;
            cell_value <= word;
        end
    end

    // monitor: every strobed path word against the oldest expectation
    always @(posedge clk)
    begin : watch
        path_word_t want;
        if (rst_n && result_valid)
        begin
            words_seen++;
            if (path_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected path word: value %h last %b",
                             path_value, path_last);
            end
            else
            begin
                want = path_expect_q.pop_front();
                if (path_value !== want.value || path_last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("path word mismatch: expected %h/%b got %h/%b",
                                 want.value, want.last, path_value, path_last);
                end
            end
        end
    end

    // register write over the cfg channel, model updated at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == gsaw_pkg::CFG_NUM_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued word is in and every path word is out,
    // looking between edges so the driver's last update has landed
    task automatic settle();
        do
        begin
            @(negedge clk);
        end
        while (cell_q.size() != 0 || start || busy || path_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new grid size, only once the block has gone quiet
    task automatic size_grid(input logic [DIM_W-1:0] rows_raw,
                             input logic [DIM_W-1:0] cols_raw);
        settle();
        write_reg(gsaw_pkg::CFG_NUM_ROWS, rows_raw);
        write_reg(gsaw_pkg::CFG_NUM_COLS, cols_raw);
    endtask

    task automatic push_cell(input logic signed [DATA_W-1:0] v);
        cell_q.push_back(v);
        cells_pushed++;
    endtask

    // raw register value: mostly small grids, a few full or clamped ones
    function automatic logic [DIM_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return DIM_W'($urandom_range(1, 3));
        else if (pick < 16)
            return DIM_W'($urandom_range(4, 5));
        else if (pick == 16)
            return '0;
        else if (pick == 17)
            return DIM_W'($urandom_range(9, 15));
        else
            return DIM_W'($urandom_range(6, 8));
    endfunction

    function automatic logic signed [DATA_W-1:0] gen_cell(input fill_t fill,
                                                          input int idx);
        int t;
        case (fill)
            FILL_TIES:
                t = int'($urandom_range(0, 4)) - 2;
            FILL_RAMP:
                // rising in load order so climbs run long
                t = idx * 4096 - 100000 + int'($urandom_range(0, 4095));
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0: t = 32'h8000_0000;
                    1: t = 32'h7fff_ffff;
                    2: t = 0;
                    3: t = -1;
                    default: t = 1;
                endcase
            default:
                t = $urandom;
        endcase
        return t;
    endfunction

    // one grid load; a split load changes the size midway
    task automatic load_grid(input logic [DIM_W-1:0] rows_raw,
                             input logic [DIM_W-1:0] cols_raw,
                             input fill_t fill, input bit split);
        int total, part, rest, i;
        size_grid(rows_raw, cols_raw);
        total = fit_dim(rows_raw, ROWS_MAX) * fit_dim(cols_raw, COLS_MAX);
        if (split && total > 1)
        begin
            part = $urandom_range(1, total - 1);
            for (i = 0; i < part; i++)
                push_cell(gen_cell(fill, i));
            size_grid(pick_dim(), pick_dim());
            total = fit_dim(rows_reg, ROWS_MAX) * fit_dim(cols_reg, COLS_MAX);
            // an overrun load completes with a single word
            rest = (cells_loaded >= total) ? 1 : total - cells_loaded;
            for (i = 0; i < rest; i++)
                push_cell(gen_cell(fill, part + i));
        end
        else
        begin
            for (i = 0; i < total; i++)
                push_cell(gen_cell(fill, i));
        end
    endtask

    initial
    begin : stimulus
        int i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single cell grids at the value extremes
        size_grid(4'd1, 4'd1);
        push_cell(32'h8000_0000);
        push_cell(32'h7fff_ffff);

        // zero sizes act as one
        size_grid(4'd0, 4'd0);
        push_cell(-32'sd1);

        // one row, one step up
        size_grid(4'd1, 4'd2);
        push_cell(-32'sd5);
        push_cell(32'sd7);

        // equal largest neighbors, the first in scan order wins
        size_grid(4'd2, 4'd2);
        push_cell(32'sd0);
        push_cell(32'sd5);
        push_cell(32'sd5);
        push_cell(32'sd3);

        // grid shrinks under a half-done load, next word ends it
        size_grid(4'd3, 4'd3);
        push_cell(32'sd10);
        push_cell(-32'sd3);
        push_cell(32'sd40);
        push_cell(32'sd7);
        push_cell(32'sd99);
        size_grid(4'd2, 4'd2);
        push_cell(32'sd50);

        // oversize row count clamps to the maximum, climb runs the column
        size_grid(4'd15, 4'd1);
        for (i = 0; i < ROWS_MAX; i++)
            push_cell(i * 1000 - 3000);

        // full grid with clamped sizes, then random loads
        load_grid(4'd15, 4'd15, FILL_RAMP, 1'b0);
        while (cells_pushed < 210)
        begin
            if (cells_pushed < 100)
                idle_pct = 37;
            else if (cells_pushed < 160)
                idle_pct = 63;
            else
                idle_pct = 0;
            load_grid(pick_dim(), pick_dim(), fill_t'($urandom_range(0, 3)),
                      $urandom_range(0, 6) == 0);
        end

        // drain and let the block go quiet
        settle();
        repeat (30) @(posedge clk);
        if (path_expect_q.size() != 0)
            err_count++;

        $display("run covered %0d cell words, %0d climbs, %0d path words, %0d register writes",
                 cells_taken, climbs_seen, words_seen, reg_writes);
        $display("grid sizes from 1x1 to 8x8 with zero and oversize settings, %0d errors",
                 err_count);
        if (err_count == 0)
            $display("grid_steepest_ascent_walk_test: clean");
        else
            $display("grid_steepest_ascent_walk_test: errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("grid_steepest_ascent_walk_test: errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/gsaw_pkg.sv
design/gsaw_cell_ram.sv
design/grid_steepest_ascent_walk.sv
tb/grid_steepest_ascent_walk_test.sv
